// ----- rtl/core/bte_pkg.sv -----
// Shared types, constants and the per-button frame update for the turbo/autohold engine.
package bte_pkg;

	localparam int BUTTONS_DEF = 32;
	localparam int MASK_W = 32;
	localparam int PAT_W = 32;
	localparam int LEN_W = 6;
	localparam int STEP_W = 5;
	localparam int IDX_IN_W = 6;
	localparam int TLEN_IN_W = 8;
	localparam logic [TLEN_IN_W-1:0] MAX_TURBO_LEN = 8'd32;

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic             pressed;
		logic             turbo_on;
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] length;
	} pend_rec_t;

	typedef struct packed {
		logic              [PAT_W-1:0] pattern;
		logic              [LEN_W-1:0] length;
		logic              [STEP_W-1:0] step;
	} act_rec_t;

	typedef struct packed {
		logic              valid;
		logic [MASK_W-1:0] mask;
	} result_t;

	localparam int PEND_W = $bits(pend_rec_t);
	localparam int ACT_W = $bits(act_rec_t);

	function automatic logic [LEN_W-1:0] sat_length(input logic [TLEN_IN_W-1:0] len);
		logic [LEN_W-1:0] r;
		if (len > MAX_TURBO_LEN) begin
			r = LEN_W'(MAX_TURBO_LEN);
		end else begin
			r = len[LEN_W-1:0];
		end
		return r;
	endfunction

	// Returns the updated active record; level comes out through the output argument.
	function automatic act_rec_t tick_rec(input pend_rec_t p, input act_rec_t a,
			input logic hold, output logic level);
		act_rec_t        r;
		logic [LEN_W-1:0] nxt;
		r = a;
		if ((a.pattern != p.pattern) || (a.length != p.length)) begin
			r.step = '0;
			r.pattern = p.pattern;
			r.length = p.length;
		end
		level = p.pressed | hold;
		if (p.turbo_on) begin
			level = level & r.pattern[r.step];
			nxt = LEN_W'(r.step) + LEN_W'(1);
			if (nxt >= r.length) begin
				nxt = '0;
			end
			r.step = nxt[STEP_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/bte_ram.sv -----
// Single-port-write, single-port-read synchronous memory with a registered read.
module bte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/core/bte_ctrl.sv -----
// Command sequencer: set writes, autohold clearing and the per-frame sweep over both memories.
module bte_ctrl #(
	parameter int BUTTONS = bte_pkg::BUTTONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [bte_pkg::IDX_IN_W-1:0]   button_index,
	input  logic                           pressed,
	input  logic                           turbo_enable,
	input  logic [bte_pkg::PAT_W-1:0]      turbo_pattern,
	input  logic [bte_pkg::TLEN_IN_W-1:0]  turbo_length,
	input  logic                           suppress,
	input  logic                           autohold_enable,
	input  logic                           slot_free,
	output bte_pkg::result_t               res
);

	localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(BUTTONS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [IDX_W-1:0]              iss_q;
	logic                          iss_done_q;
	logic                          rd_v_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic [BUTTONS-1:0]            pend_valid_q;
	logic [BUTTONS-1:0]            act_valid_q;
	logic [BUTTONS-1:0]            hold_q;
	logic [bte_pkg::MASK_W-1:0]    mask_q;

	logic                          accept;
	logic                          set_hit;
	logic [IDX_W-1:0]              set_idx;
	logic [IDX_W-1:0]              rd_addr;
	logic [bte_pkg::PEND_W-1:0]    pend_rd;
	logic [bte_pkg::ACT_W-1:0]     act_rd;
	bte_pkg::pend_rec_t            pend_wr;
	bte_pkg::pend_rec_t            pend_cur;
	bte_pkg::act_rec_t             act_cur;
	bte_pkg::act_rec_t             act_new;
	logic                          level;
	logic [5:0]                    idx_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign set_hit = accept && (bte_pkg::cmd_t'(command) == bte_pkg::CMD_SET)
		&& ({1'b0, button_index} < 7'(BUTTONS));
	assign set_idx = IDX_W'(button_index);
	assign rd_addr = (state_q == ST_SWEEP) ? iss_q : '0;

	assign pend_wr.pressed = pressed;
	assign pend_wr.turbo_on = turbo_enable;
	assign pend_wr.pattern = turbo_pattern;
	assign pend_wr.length = bte_pkg::sat_length(turbo_length);

	bte_ram #(.WIDTH(bte_pkg::PEND_W), .DEPTH(BUTTONS), .AW(IDX_W)) u_pend (
		.clk     (clk),
		.wr_en   (set_hit),
		.wr_addr (set_idx),
		.wr_data (pend_wr),
		.rd_addr (rd_addr),
		.rd_data (pend_rd)
	);

	always_comb begin
		pend_cur = pend_valid_q[idx_s1] ? bte_pkg::pend_rec_t'(pend_rd) : '0;
		act_cur = act_valid_q[idx_s1] ? bte_pkg::act_rec_t'(act_rd) : '0;
		act_new = bte_pkg::tick_rec(pend_cur, act_cur, hold_q[idx_s1], level);
	end

	bte_ram #(.WIDTH(bte_pkg::ACT_W), .DEPTH(BUTTONS), .AW(IDX_W)) u_act (
		.clk     (clk),
		.wr_en   (rd_v_s1),
		.wr_addr (idx_s1),
		.wr_data (act_new),
		.rd_addr (rd_addr),
		.rd_data (act_rd)
	);

	assign idx_ext = 6'(idx_s1);
	assign res.valid = (state_q == ST_DONE) && slot_free;
	assign res.mask = mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q <= '0;
			iss_done_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			idx_s1 <= '0;
			pend_valid_q <= '0;
			act_valid_q <= '0;
			hold_q <= '0;
			mask_q <= '0;
		end else begin
			if (set_hit) begin
				pend_valid_q[set_idx] <= 1'b1;
				if (autohold_enable && pressed) begin
					hold_q[set_idx] <= 1'b1;
				end
			end
			if (rd_v_s1) begin
				act_valid_q[idx_s1] <= 1'b1;
				if ((idx_ext < 6'd32) && level) begin
					mask_q[idx_ext[4:0]] <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (accept) begin
						case (bte_pkg::cmd_t'(command))
							bte_pkg::CMD_CLEAR: hold_q <= '0;
							bte_pkg::CMD_TICK: begin
								mask_q <= '0;
								if (suppress) begin
									act_valid_q <= '0;
									state_q <= ST_DONE;
								end else begin
									iss_q <= '0;
									iss_done_q <= 1'b0;
									state_q <= ST_SWEEP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					rd_v_s1 <= !iss_done_q;
					idx_s1 <= iss_q;
					if (!iss_done_q) begin
						if (iss_q == LAST) begin
							iss_done_q <= 1'b1;
						end else begin
							iss_q <= iss_q + IDX_W'(1);
						end
					end
					if (rd_v_s1 && (idx_s1 == LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rd_v_s1 <= 1'b0;
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/button_turbo_autohold_engine_top.sv -----
// Top level of the button turbo/autohold engine: ports, configuration and result registers.
//
//  Channel  Signals                                   Direction
//  cfg      cfg_valid/cfg_ready, cfg_data             in
//  in       in_valid/in_ready, command .. suppress    in
//  out      out_valid/out_ready, pressed_mask         out
//
// A frame tick sweeps one button per cycle through both memories, each with a single
// read port. Reset clears all valid bits at once, so no clearing pass is needed.
// A result waiting on out_ready does not block set and clear beats.
module button_turbo_autohold_engine_top #(
	parameter int BUTTONS = bte_pkg::BUTTONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [bte_pkg::IDX_IN_W-1:0]   button_index,
	input  logic                           pressed,
	input  logic                           turbo_enable,
	input  logic [bte_pkg::PAT_W-1:0]      turbo_pattern,
	input  logic [bte_pkg::TLEN_IN_W-1:0]  turbo_length,
	input  logic                           suppress,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bte_pkg::MASK_W-1:0]     pressed_mask
);

	logic                       autohold_enable_q;
	logic                       out_valid_q;
	logic [bte_pkg::MASK_W-1:0] mask_q;
	logic                       slot_free;
	bte_pkg::result_t           res;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign pressed_mask = mask_q;

	bte_ctrl #(.BUTTONS(BUTTONS)) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.button_index    (button_index),
		.pressed         (pressed),
		.turbo_enable    (turbo_enable),
		.turbo_pattern   (turbo_pattern),
		.turbo_length    (turbo_length),
		.suppress        (suppress),
		.autohold_enable (autohold_enable_q),
		.slot_free       (slot_free),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			autohold_enable_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				autohold_enable_q <= cfg_data;
			end
			if (res.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			mask_q <= res.mask;
		end
	end

endmodule
